// ===== hw/rtl/pbt_pkg.sv =====
// Shared types and constants of the polyline Bezier tessellator.
package pbt_pkg;

  localparam int TFRAC = 15;
  localparam int SEG_LEN_W = 8;
  localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 8'd10;
  localparam int DEF_MAX_SEGMENTS = 63;
  localparam int DEF_COORD_WIDTH = 16;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DX2,
    ST_DY2,
    ST_DSUM,
    ST_SQRT,
    ST_DNEXT,
    ST_TQ0,
    ST_DIV,
    ST_TQ1,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_Q4,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_K4,
    ST_K5,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_P6,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/polyline_bezier_tessellator.sv =====
// Quadratic Bezier tessellator for a stream of polyline points.
//
// Input words on s_axis carry one point (x, y signed with 4 fraction bits)
// and tlast marks the final point of a polyline. From the third point on,
// each word closes a window of three points and the block emits m+1 curve
// points on m_axis, where m is the summed length of the window's two legs over the
// segment length, clamped to 1..MAX_SEGMENTS. tlast marks the last point of a run and
// tuser[0] the last point of the whole curve. cfg_we writes the segment
// length in whole pixels; zero acts as one.
// The block takes one word at a time and s_axis_tready is low while it works.
// A word that closes no window only updates the held points. Otherwise the work
// runs through the two distances, then the curve parameter, the control point
// and m (less for a degenerate window), then each emitted point in turn. The
// divider is bit-serial, one quotient bit per cycle. A stalled receiver holds
// the output register and the sequencer waits. Reset clears the held points,
// the point count and the output valid flag, and sets the segment length to 10.
module polyline_bezier_tessellator
  import pbt_pkg::*;
#(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Bits from low: point_x, point_y, zero fill.
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // Bits from low: out_x, out_y, zero fill.
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // Bits from low: curve_end.
  output logic [0:0] m_axis_tuser,
  input  logic cfg_we,
  input  logic [SEG_LEN_W-1:0] cfg_wdata
);

  localparam int CW = COORD_WIDTH;
  localparam int TDW = ((2*CW+7)/8)*8;
  localparam int DW = CW + 1;
  localparam int RW = 2 * DW;
  localparam int NW = CW + 32;
  localparam int ACW = CW + 33;
  localparam int CXW = CW + 16;
  localparam int MAW = CXW;
  localparam int MBW = (CW + 2 > 32) ? CW + 2 : 32;
  localparam int PW = MAW + MBW;
  localparam int DDW = (CW + 3 > 30) ? CW + 3 : 30;
  localparam int MW = $clog2(MAX_SEGMENTS + 1);
  localparam int MSQW = 2 * MW;
  localparam int CNTW = $clog2(NW + 1);
  localparam int LENW = SEG_LEN_W + 4;
  localparam int QW = 2 * TFRAC + 1;
  localparam logic [TFRAC:0] T_ONE = (TFRAC+1)'(1) << TFRAC;
  localparam logic signed [NW:0] SAT_HI = {{(NW+2-CW){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NW:0] SAT_LO = ~SAT_HI;

  state_t state, state_next;

  logic [SEG_LEN_W-1:0] seg_len;
  logic signed [CW-1:0] prev_x0, prev_x1, prev_y0, prev_y1;
  logic [1:0] points_seen;
  logic signed [CW-1:0] wx0, wy0, wx1, wy1, wx2, wy2;
  logic wlast;
  logic dist_sel, coord_sel;
  logic [DW-1:0] da, db, root;
  logic [RW-1:0] rad;
  logic [DW+1:0] srem;
  logic [TFRAC:0] tq, uq;
  logic [QW-1:0] uq2, tq2;
  logic [DDW-1:0] cden;
  logic signed [CXW-1:0] cx, cy;
  logic [MW-1:0] m, idx;
  logic [MSQW-1:0] msq, c0, c2;
  logic signed [CW-1:0] ox, oy;
  logic signed [PW-1:0] prod;
  logic signed [ACW-1:0] acc;
  logic [NW-1:0] dq;
  logic [DDW-1:0] drem, dden;
  logic dneg;
  logic [CNTW-1:0] dcnt;
  state_t dret;

  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic div_go, div_rnd;
  logic signed [ACW-1:0] div_val, dv_abs;
  logic [DDW-1:0] div_den;
  state_t div_ret;
  logic [NW-1:0] div_mag;

  logic in_acc, out_free;
  logic signed [CW-1:0] px, py, mx0, my0, mx2, my2;
  logic signed [CW:0] ddx, ddy, sum_x0, sum_y0, sum_x2, sum_y2;
  logic [DW:0] s;
  logic [LENW-1:0] len;
  logic [MSQW-1:0] c1;
  logic signed [CW-1:0] p0_sel, p1_sel, p2_sel;
  logic signed [CXW-1:0] c_sel;
  logic [DW+3:0] sq_rem_n, sq_trial, sq_diff;
  logic [DDW:0] dv_rem_n, dv_diff;
  logic signed [NW:0] qs;
  logic signed [CW-1:0] qsat;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign px = s_axis_tdata[CW-1:0];
  assign py = s_axis_tdata[2*CW-1:CW];
  assign sum_x0 = {prev_x0[CW-1], prev_x0} + {prev_x1[CW-1], prev_x1};
  assign sum_y0 = {prev_y0[CW-1], prev_y0} + {prev_y1[CW-1], prev_y1};
  assign sum_x2 = {prev_x1[CW-1], prev_x1} + {px[CW-1], px};
  assign sum_y2 = {prev_y1[CW-1], prev_y1} + {py[CW-1], py};
  assign mx0 = (points_seen == 2'd2) ? prev_x0 : sum_x0[CW:1];
  assign my0 = (points_seen == 2'd2) ? prev_y0 : sum_y0[CW:1];
  assign mx2 = s_axis_tlast ? px : sum_x2[CW:1];
  assign my2 = s_axis_tlast ? py : sum_y2[CW:1];

  assign ddx = dist_sel ? ({wx2[CW-1], wx2} - {wx1[CW-1], wx1})
                        : ({wx1[CW-1], wx1} - {wx0[CW-1], wx0});
  assign ddy = dist_sel ? ({wy2[CW-1], wy2} - {wy1[CW-1], wy1})
                        : ({wy1[CW-1], wy1} - {wy0[CW-1], wy0});
  assign s = {1'b0, da} + {1'b0, db};
  assign len = {((seg_len == '0) ? SEG_LEN_W'(1) : seg_len), 4'b0000};
  assign c1 = msq - c0 - c2;
  assign p0_sel = coord_sel ? wy0 : wx0;
  assign p1_sel = coord_sel ? wy1 : wx1;
  assign p2_sel = coord_sel ? wy2 : wx2;
  assign c_sel = coord_sel ? cy : cx;

  assign sq_rem_n = {srem, rad[RW-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_diff = sq_rem_n - sq_trial;
  assign dv_rem_n = {drem, dq[NW-1]};
  assign dv_diff = dv_rem_n - {1'b0, dden};
  assign qs = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign qsat = (qs > SAT_HI) ? SAT_HI[CW-1:0] :
                (qs < SAT_LO) ? SAT_LO[CW-1:0] : qs[CW-1:0];

  assign dv_abs = (div_val < 0) ? -div_val : div_val;
  assign div_mag = NW'(dv_abs) + (div_rnd ? NW'(div_den >> 1) : NW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    div_go = 1'b0;
    div_rnd = 1'b1;
    div_val = '0;
    div_den = '0;
    div_ret = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && points_seen >= 2'd2) begin
          state_next = ST_DX2;
        end
      end
      ST_DX2: begin
        mul_a = MAW'(ddx);
        mul_b = MBW'(ddx);
        state_next = ST_DY2;
      end
      ST_DY2: begin
        mul_a = MAW'(ddy);
        mul_b = MBW'(ddy);
        state_next = ST_DSUM;
      end
      ST_DSUM: state_next = ST_SQRT;
      ST_SQRT: begin
        if (dcnt == CNTW'(1)) begin
          state_next = ST_DNEXT;
        end
      end
      ST_DNEXT: state_next = dist_sel ? ST_TQ0 : ST_DX2;
      ST_TQ0: begin
        if (da == '0 || db == '0) begin
          state_next = ST_M0;
        end else begin
          div_go = 1'b1;
          div_val = $signed(ACW'({da, {TFRAC{1'b0}}}));
          div_den = DDW'(s);
          div_ret = ST_TQ1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dcnt == CNTW'(1)) begin
          state_next = dret;
        end
      end
      ST_TQ1: begin
        if (dq == '0 || dq >= NW'(T_ONE)) begin
          state_next = ST_M0;
        end else begin
          state_next = ST_Q1;
        end
      end
      ST_Q1: begin
        mul_a = MAW'(uq);
        mul_b = MBW'(uq);
        state_next = ST_Q2;
      end
      ST_Q2: begin
        mul_a = MAW'(tq);
        mul_b = MBW'(tq);
        state_next = ST_Q3;
      end
      ST_Q3: begin
        mul_a = MAW'(tq);
        mul_b = MBW'(uq);
        state_next = ST_Q4;
      end
      ST_Q4: state_next = ST_K1;
      ST_K1: begin
        mul_a = MAW'(p0_sel);
        mul_b = MBW'(uq2);
        state_next = ST_K2;
      end
      ST_K2: begin
        mul_a = MAW'(p2_sel);
        mul_b = MBW'(tq2);
        state_next = ST_K3;
      end
      ST_K3: state_next = ST_K4;
      ST_K4: begin
        div_go = 1'b1;
        div_val = acc;
        div_den = cden;
        div_ret = ST_K5;
        state_next = ST_DIV;
      end
      ST_K5: state_next = coord_sel ? ST_M0 : ST_K1;
      ST_M0: begin
        div_go = 1'b1;
        div_rnd = 1'b0;
        div_val = ACW'(s) + ACW'(len) - ACW'(1);
        div_den = DDW'(len);
        div_ret = ST_M1;
        state_next = ST_DIV;
      end
      ST_M1: state_next = ST_M2;
      ST_M2: begin
        mul_a = MAW'(m);
        mul_b = MBW'(m);
        state_next = ST_M3;
      end
      ST_M3: state_next = ST_P1;
      ST_P1: begin
        mul_a = MAW'(p0_sel);
        mul_b = MBW'(c0);
        state_next = ST_P2;
      end
      ST_P2: begin
        mul_a = c_sel;
        mul_b = MBW'(c1);
        state_next = ST_P3;
      end
      ST_P3: begin
        mul_a = MAW'(p2_sel);
        mul_b = MBW'(c2);
        state_next = ST_P4;
      end
      ST_P4: state_next = ST_P5;
      ST_P5: begin
        div_go = 1'b1;
        div_val = acc;
        div_den = DDW'(msq);
        div_ret = ST_P6;
        state_next = ST_DIV;
      end
      ST_P6: state_next = coord_sel ? ST_EMIT : ST_P1;
      ST_EMIT: begin
        if (out_free) begin
          state_next = (idx == m) ? ST_IDLE : ST_P1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len <= SEG_LEN_RESET;
    end else if (cfg_we) begin
      seg_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x0 <= '0;
      prev_x1 <= '0;
      prev_y0 <= '0;
      prev_y1 <= '0;
      points_seen <= '0;
    end else if (in_acc) begin
      prev_x0 <= prev_x1;
      prev_y0 <= prev_y1;
      prev_x1 <= px;
      prev_y1 <= py;
      if (s_axis_tlast) begin
        points_seen <= '0;
      end else if (points_seen != 2'd3) begin
        points_seen <= points_seen + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (div_go) begin
      dq <= div_mag;
      drem <= '0;
      dden <= div_den;
      dneg <= (div_val < 0);
      dret <= div_ret;
      dcnt <= CNTW'(NW);
    end
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          wx0 <= mx0;
          wy0 <= my0;
          wx1 <= prev_x1;
          wy1 <= prev_y1;
          wx2 <= mx2;
          wy2 <= my2;
          wlast <= s_axis_tlast;
          dist_sel <= 1'b0;
        end
      end
      ST_DY2: rad <= prod[RW-1:0];
      ST_DSUM: begin
        rad <= rad + prod[RW-1:0];
        root <= '0;
        srem <= '0;
        dcnt <= CNTW'(DW);
      end
      ST_SQRT: begin
        if (sq_rem_n >= sq_trial) begin
          srem <= sq_diff[DW+1:0];
          root <= {root[DW-2:0], 1'b1};
        end else begin
          srem <= sq_rem_n[DW+1:0];
          root <= {root[DW-2:0], 1'b0};
        end
        rad <= {rad[RW-3:0], 2'b00};
        dcnt <= dcnt - CNTW'(1);
      end
      ST_DNEXT: begin
        if (dist_sel) begin
          db <= root;
        end else begin
          da <= root;
          dist_sel <= 1'b1;
        end
      end
      ST_TQ0: begin
        cx <= CXW'(wx1);
        cy <= CXW'(wy1);
      end
      ST_DIV: begin
        if (dv_rem_n >= {1'b0, dden}) begin
          drem <= dv_diff[DDW-1:0];
          dq <= {dq[NW-2:0], 1'b1};
        end else begin
          drem <= dv_rem_n[DDW-1:0];
          dq <= {dq[NW-2:0], 1'b0};
        end
        dcnt <= dcnt - CNTW'(1);
      end
      ST_TQ1: begin
        tq <= dq[TFRAC:0];
        uq <= T_ONE - dq[TFRAC:0];
      end
      ST_Q2: uq2 <= prod[QW-1:0];
      ST_Q3: tq2 <= prod[QW-1:0];
      ST_Q4: begin
        cden <= {prod[DDW-2:0], 1'b0};
        coord_sel <= 1'b0;
      end
      ST_K2: acc <= (ACW'(p1_sel) <<< (2*TFRAC)) - $signed(prod[ACW-1:0]);
      ST_K3: acc <= acc - $signed(prod[ACW-1:0]);
      ST_K5: begin
        if (coord_sel) begin
          cy <= qs[CXW-1:0];
        end else begin
          cx <= qs[CXW-1:0];
        end
        coord_sel <= 1'b1;
      end
      ST_M1: begin
        if (dq == '0) begin
          m <= MW'(1);
        end else if (dq > NW'(MAX_SEGMENTS)) begin
          m <= MW'(MAX_SEGMENTS);
        end else begin
          m <= dq[MW-1:0];
        end
      end
      ST_M3: begin
        msq <= prod[MSQW-1:0];
        c0 <= prod[MSQW-1:0];
        c2 <= '0;
        idx <= '0;
        coord_sel <= 1'b0;
      end
      ST_P2: acc <= $signed(prod[ACW-1:0]);
      ST_P3: acc <= acc + $signed(prod[ACW-1:0]);
      ST_P4: acc <= acc + $signed(prod[ACW-1:0]);
      ST_P6: begin
        if (coord_sel) begin
          oy <= qsat;
        end else begin
          ox <= qsat;
        end
        coord_sel <= 1'b1;
      end
      ST_EMIT: begin
        if (out_free && idx != m) begin
          c0 <= c0 - MSQW'({m - idx, 1'b0}) + MSQW'(1);
          c2 <= c2 + MSQW'({idx, 1'b0}) + MSQW'(1);
          idx <= idx + MW'(1);
          coord_sel <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_axis_tdata <= TDW'({oy, ox});
      m_axis_tlast <= (idx == m);
      m_axis_tuser <= (idx == m) && wlast;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && m_axis_tvalid && !m_axis_tready) |=> state == ST_EMIT)
    else $error("sequencer left the emit state while the output was stalled");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> idx <= m)
    else $error("point index ran past the segment count");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_P1) |-> (m >= MW'(1) && m <= MW'(MAX_SEGMENTS)))
    else $error("segment count outside its clamp range");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("curve end flagged on a word that does not close its run");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the polyline Bezier tessellator.
`timescale 1ns / 100ps

module testbench;
  import pbt_pkg::*;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int MAXSEG = DEF_MAX_SEGMENTS;
  localparam int DW = ((2*CW+7)/8)*8;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic run_last;
    logic curve_end;
  } curve_pt_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic last;
    int seg_len;
    int n_words;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [DW-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [0:0] m_axis_tuser;
  logic cfg_we = 0;
  logic [SEG_LEN_W-1:0] cfg_wdata = '0;

  polyline_bezier_tessellator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  longint seg_len_q;
  longint held_x[2], held_y[2];
  int pts_seen;
  curve_pt_t curve_q[$];
  int errors = 0;
  int words_in = 0, words_out = 0, polylines = 0;
  longint cycles = 0;
  bit long_stall = 0;

  function automatic longint mid_floor(longint s);
    return (s >= 0) ? s / 2 : -((-s + 1) / 2);
  endfunction

  function automatic longint round_div(longint num, longint den);
    return (num >= 0) ? (num + den / 2) / den : -((-num + den / 2) / den);
  endfunction

  function automatic longint clip(longint v);
    longint hi;
    hi = (longint'(1) <<< (CW-1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint isqrt_dist(longint ax, longint ay, longint bx, longint by);
    longint dx, dy, r, sq;
    dx = bx - ax; dy = by - ay;
    sq = dx*dx + dy*dy;
    r = longint'($sqrt(real'(sq)));
    while (r*r > sq) r--;
    while ((r+1)*(r+1) <= sq) r++;
    return r;
  endfunction

  function automatic longint ctrl_coord(longint p0, longint p1, longint p2,
                                        longint tq, longint uq);
    return round_div(p1 * (longint'(1) <<< (2*TFRAC)) - uq*uq*p0 - tq*tq*p2,
                     2*tq*uq);
  endfunction

  task automatic predict_curve(logic signed [CW-1:0] px_in, logic signed [CW-1:0] py_in,
                               logic last);
    longint px, py, x0, y0, x1, y1, x2, y2, cx, cy, a, b, s, len, m, tq, uq;
    longint c0, c1, c2, den;
    curve_pt_t pt;
    px = px_in; py = py_in;
    if (pts_seen >= 2) begin
      x1 = held_x[1]; y1 = held_y[1];
      if (pts_seen == 2) begin
        x0 = held_x[0]; y0 = held_y[0];
      end else begin
        x0 = mid_floor(held_x[0] + held_x[1]);
        y0 = mid_floor(held_y[0] + held_y[1]);
      end
      if (last) begin
        x2 = px; y2 = py;
      end else begin
        x2 = mid_floor(x1 + px); y2 = mid_floor(y1 + py);
      end
      a = isqrt_dist(x0, y0, x1, y1);
      b = isqrt_dist(x1, y1, x2, y2);
      s = a + b;
      cx = x1; cy = y1;
      if (a != 0 && b != 0) begin
        tq = ((a <<< TFRAC) + s / 2) / s;
        uq = (longint'(1) <<< TFRAC) - tq;
        if (tq > 0 && uq > 0) begin
          cx = ctrl_coord(x0, x1, x2, tq, uq);
          cy = ctrl_coord(y0, y1, y2, tq, uq);
        end
      end
      len = (seg_len_q == 0 ? 1 : seg_len_q) * 16;
      m = (s + len - 1) / len;
      if (m < 1) m = 1;
      if (m > MAXSEG) m = MAXSEG;
      for (longint i = 0; i <= m; i++) begin
        c0 = (m-i)*(m-i); c1 = 2*i*(m-i); c2 = i*i; den = m*m;
        pt.x = clip(round_div(c0*x0 + c1*cx + c2*x2, den));
        pt.y = clip(round_div(c0*y0 + c1*cy + c2*y2, den));
        pt.run_last = (i == m);
        pt.curve_end = (i == m) && last;
        curve_q.insert(curve_q.size(), pt);
      end
    end
    held_x[0] = held_x[1]; held_y[0] = held_y[1];
    held_x[1] = px; held_y[1] = py;
    if (pts_seen < 3) pts_seen++;
    if (last) begin
      pts_seen = 0;
      polylines++;
    end
  endtask

  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic last,
                            bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= DW'({y, x});
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_curve(x, y, last);
    words_in++;
  endtask

  task automatic drain_then_config(int value);
    s_axis_tvalid <= 0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value[SEG_LEN_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    seg_len_q = value & 8'hFF;
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      if (long_stall) begin
        hold = 3000;
        long_stall = 0;
      end else begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        m_axis_tready <= 0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    curve_pt_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (curve_q.size() == 0) begin
        $error("unexpected output word x=%0d y=%0d",
               $signed(m_axis_tdata[CW-1:0]), $signed(m_axis_tdata[2*CW-1:CW]));
        errors++;
      end else begin
        want = curve_q.pop_front();
        if (m_axis_tdata[CW-1:0] !== want.x) begin
          $error("out_x expected %0d got %0d", want.x, $signed(m_axis_tdata[CW-1:0]));
          errors++;
        end
        if (m_axis_tdata[2*CW-1:CW] !== want.y) begin
          $error("out_y expected %0d got %0d", want.y, $signed(m_axis_tdata[2*CW-1:CW]));
          errors++;
        end
        if (m_axis_tlast !== want.run_last) begin
          $error("last_of_run expected %0b got %0b", want.run_last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser[0] !== want.curve_end) begin
          $error("curve_end expected %0b got %0b", want.curve_end, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** polyline_bezier_tessellator: FAILED **");
      $finish;
    end
  end

  // Directed rows; seg_len of -1 keeps the current register value, and n_words of -1
  // leaves the word count to the predictor alone.
  stim_row_t directed[] = '{
    '{16'sd0, 16'sd0, 1'b1, -1, 0},
    '{16'sd100, 16'sd0, 1'b0, -1, 0},
    '{16'sd200, 16'sd0, 1'b1, -1, 0},
    '{16'sd0, 16'sd0, 1'b0, -1, 0},
    '{16'sd0, 16'sd0, 1'b0, -1, 0},
    '{16'sd0, 16'sd0, 1'b1, -1, 2},
    '{16'sd0, 16'sd0, 1'b0, 255, 0},
    '{16'sd160, 16'sd320, 1'b0, -1, 0},
    '{16'sd800, -16'sd40, 1'b0, -1, -1},
    '{16'sd1000, 16'sd500, 1'b1, -1, -1},
    '{16'sh8000, 16'sh8000, 1'b0, 1, 0},
    '{16'sd32767, 16'sd32767, 1'b0, -1, 0},
    '{16'sh8000, 16'sd32767, 1'b0, -1, -1},
    '{16'sd32767, 16'sh8000, 1'b1, -1, -1},
    '{16'sd5, 16'sd5, 1'b0, 0, 0},
    '{16'sd5, 16'sd5, 1'b0, -1, 0},
    '{16'sd300, 16'sd7, 1'b0, -1, -1},
    '{16'sd301, 16'sd9, 1'b1, -1, -1},
    '{-16'sd1, -16'sd1, 1'b0, 10, 0},
    '{-16'sd3, 16'sd2, 1'b0, -1, 0},
    '{16'sd4000, -16'sd3000, 1'b0, -1, -1},
    '{-16'sd2, 16'sd8, 1'b1, -1, -1}
  };

  initial begin
    int n, sel, words_before;
    logic signed [CW-1:0] bx, by;
    seg_len_q = SEG_LEN_RESET;
    held_x = '{0, 0}; held_y = '{0, 0};
    pts_seen = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Short polylines and a zero-length window also have their word count typed in.
    foreach (directed[k]) begin
      if (directed[k].seg_len >= 0) drain_then_config(directed[k].seg_len);
      if (directed[k].n_words >= 0) begin
        s_axis_tvalid <= 0;
        do @(posedge clk); while (curve_q.size() != 0);
      end
      words_before = words_out;
      send_point(directed[k].x, directed[k].y, directed[k].last, 1'b1);
      if (directed[k].n_words >= 0) begin
        s_axis_tvalid <= 0;
        while (curve_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (words_out - words_before != directed[k].n_words) begin
          $error("word count expected %0d got %0d", directed[k].n_words,
                 words_out - words_before);
          errors++;
        end
      end
    end

    long_stall = 1;
    for (int k = 0; k < 6; k++)
      send_point(CW'($urandom_range(0, 4000)), CW'($urandom_range(0, 4000)), k == 5, 1'b0);
    drain_then_config($urandom_range(1, 255));

    n = 0;
    while (n < 82) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) drain_then_config($urandom_range(0, 3) == 0 ? 255 : $urandom_range(1, 40));
      if (sel == 1) begin
        send_point(CW'($urandom), CW'($urandom), $urandom_range(0, 1) == 1, 1'b1);
        n++;
      end else begin
        bx = CW'($urandom); by = CW'($urandom);
        for (int k = $urandom_range(3, 7); k > 0; k--) begin
          bx = CW'(bx + $signed($urandom_range(0, 1600)) - 800);
          by = CW'(by + $signed($urandom_range(0, 1600)) - 800);
          send_point(bx, by, k == 1, 1'b1);
          n++;
        end
      end
    end

    s_axis_tvalid <= 0;
    while (curve_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d points in %0d polylines, checked %0d curve points.",
             words_in, polylines, words_out);
    if (errors == 0) begin
      $display("** polyline_bezier_tessellator: PASSED **");
    end else begin
      $display("** polyline_bezier_tessellator: FAILED **");
    end
    $finish;
  end

endmodule
